// File: sv/indexed_doubly_linked_list_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the indexed doubly linked list unit
// Clocked on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef INDEXED_DOUBLY_LINKED_LIST_UNIT_ASSERT_SVH
`define INDEXED_DOUBLY_LINKED_LIST_UNIT_ASSERT_SVH

// same-cycle implication
`define IDLL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IDLL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/idll_pkg.sv
// ----------------------------------------------------------------------------
// idll_pkg
// Shared widths, request and status codes, and the result item type.
// ----------------------------------------------------------------------------
package idll_pkg;

    localparam int POOL_DEFAULT = 64;

    localparam int REQ_W     = 3;
    localparam int POS_W     = 7;
    localparam int VAL_W     = 32;
    localparam int STAT_W    = 2;
    localparam int S_TDATA_W = 40;  // position + value, padded to bytes
    localparam int M_TDATA_W = 32;

    localparam int HEAD_IDX = 0;
    localparam int TAIL_IDX = 1;
    localparam int FIRST_FREE = 2;

    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_INS_LEFT   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_INS_RIGHT  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_DUMP       = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD_POS = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd3;

    typedef struct packed {
        logic signed [VAL_W-1:0] elem_value;
        logic                    last;
        logic [STAT_W-1:0]       status;
    } result_t;

endpackage

// File: sv/idll_ram.sv
// ----------------------------------------------------------------------------
// idll_ram
// Single write port, single read port memory with a registered read.
// ----------------------------------------------------------------------------
module idll_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 66,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/idll_out_reg.sv
// ----------------------------------------------------------------------------
// idll_out_reg
// Output register of the result channel; loads a new item whenever the held
// one is taken or none is held.
// ----------------------------------------------------------------------------
module idll_out_reg (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 load,
    input  idll_pkg::result_t                    item,
    output logic                                 ready,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [idll_pkg::M_TDATA_W-1:0]       m_tdata,  // [31:0] elem_value
    output logic                                 m_tlast,
    output logic [idll_pkg::STAT_W-1:0]          m_tuser   // [1:0] status
);

    logic              valid_reg;
    logic              valid_next;
    idll_pkg::result_t item_reg;

    assign ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load && ready) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && ready) begin
            item_reg <= item;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = item_reg.elem_value;
    assign m_tlast  = item_reg.last;
    assign m_tuser  = item_reg.status;

endmodule

// File: sv/indexed_doubly_linked_list_unit.sv
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list_unit
// Doubly linked list with head and tail sentinels in link and value memories.
// ----------------------------------------------------------------------------
// Items are taken one at a time; s_tready is high only while the sequencer
// waits for a request. Node k+1 holds the k-th inserted element, nodes are
// never reused. After S_IDLE accepts a request the states run: push front and
// push back S_INS_RD, S_INS_WR, S_RESP; an insert first S_CHECK, then S_LEFT_RD
// for insert left only, then as a push; delete S_CHECK, S_DEL_RD, S_RESP; a
// request naming element 0 or one not yet inserted, or a push into a full pool,
// S_RESP; one naming a deleted element, or an insert beside an element into a
// full pool, S_CHECK, S_RESP; a dump S_DUMP, one item per element (S_RESP for
// an empty list). A request that names an element first reads its live flag,
// kept beside its value, with its links; an insert reads one link, then writes
// two entries of each link memory, since each memory has one read and one write
// port. Results wait in an output register, so a new request is taken as soon
// as the previous result is loaded there; a stalled receiver adds its stall cycles.
`include "indexed_doubly_linked_list_unit_assert.svh"

module indexed_doubly_linked_list_unit #(
    parameter int POOL = idll_pkg::POOL_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [idll_pkg::S_TDATA_W-1:0]       s_tdata,  // [6:0] position, [38:7] value
    input  logic [idll_pkg::REQ_W-1:0]           s_tuser,  // [2:0] req_type
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [idll_pkg::M_TDATA_W-1:0]       m_tdata,  // [31:0] elem_value
    output logic                                 m_tlast,
    output logic [idll_pkg::STAT_W-1:0]          m_tuser   // [1:0] status
);

    localparam int DEPTH = POOL + 2;
    localparam int NW    = $clog2(DEPTH);
    localparam int FW    = $clog2(DEPTH + 1);
    localparam int CW    = $clog2(POOL + 1);
    localparam int PW    = idll_pkg::POS_W;
    localparam int VW    = idll_pkg::VAL_W;

    localparam logic [NW-1:0] HEAD_N = NW'(idll_pkg::HEAD_IDX);
    localparam logic [NW-1:0] TAIL_N = NW'(idll_pkg::TAIL_IDX);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_LEFT_RD = 3'd1;
    localparam logic [2:0] S_INS_RD  = 3'd2;
    localparam logic [2:0] S_INS_WR  = 3'd3;
    localparam logic [2:0] S_DEL_RD  = 3'd4;
    localparam logic [2:0] S_DUMP    = 3'd5;
    localparam logic [2:0] S_RESP    = 3'd6;
    localparam logic [2:0] S_CHECK   = 3'd7;

    logic [2:0]                     state_reg, state_next;
    logic [idll_pkg::REQ_W-1:0]     req_reg, req_next;
    logic [NW-1:0]                  node_reg, node_next;
    logic [NW-1:0]                  at_reg, at_next;
    logic [NW-1:0]                  nx_reg, nx_next;
    logic [VW-1:0]                  val_reg, val_next;
    logic [idll_pkg::STAT_W-1:0]    st_reg, st_next;
    logic [FW-1:0]                  free_reg, free_next;
    logic [NW-1:0]                  head_next_reg, head_next_next;
    logic [NW-1:0]                  tail_prev_reg, tail_prev_next;
    logic [CW-1:0]                  cnt_reg, cnt_next;
    logic [NW-1:0]                  nrd_addr_reg;
    logic [NW-1:0]                  prd_addr_reg;

    logic                n_we, n_re, p_we, p_re, v_we, v_re;
    logic [NW-1:0]       n_waddr, n_raddr, p_waddr, p_raddr, v_waddr, v_raddr;
    logic [NW-1:0]       n_wdata, p_wdata, n_rdata, p_rdata;
    logic [VW:0]         v_wdata, v_rdata;  // [VW] live flag, [VW-1:0] value
    logic [NW-1:0]       next_rd, prev_rd;

    logic                out_load, out_ready;
    idll_pkg::result_t   out_item;

    logic [PW-1:0]       in_pos;
    logic [PW:0]         pos_node;
    logic                pos_ok, pool_full, dump_end;
    logic [NW-1:0]       pos_idx, new_node;

    idll_ram #(.WIDTH(NW), .DEPTH(DEPTH)) u_next_mem (
        .aclk(aclk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
        .re(n_re), .raddr(n_raddr), .rdata(n_rdata)
    );

    idll_ram #(.WIDTH(NW), .DEPTH(DEPTH)) u_prev_mem (
        .aclk(aclk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .re(p_re), .raddr(p_raddr), .rdata(p_rdata)
    );

    idll_ram #(.WIDTH(VW + 1), .DEPTH(DEPTH)) u_value_mem (
        .aclk(aclk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .re(v_re), .raddr(v_raddr), .rdata(v_rdata)
    );

    idll_out_reg u_out (
        .aclk(aclk), .aresetn(aresetn), .load(out_load), .item(out_item),
        .ready(out_ready), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    // sentinel links live in registers; memory entries at those spots were never reset
    assign next_rd = (nrd_addr_reg == HEAD_N) ? head_next_reg : n_rdata;
    assign prev_rd = (prd_addr_reg == TAIL_N) ? tail_prev_reg : p_rdata;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_pos    = s_tdata[PW-1:0];
    assign pos_node  = {1'b0, in_pos} + {{PW{1'b0}}, 1'b1};
    assign pos_idx   = pos_node[NW-1:0];
    // nodes below the allocation mark have been written, so their live flag is valid
    assign pos_ok    = (in_pos != '0) && (pos_node < (PW+1)'(free_reg));
    assign pool_full = (free_reg >= FW'(DEPTH));
    assign new_node  = free_reg[NW-1:0];
    assign dump_end  = (next_rd == TAIL_N) || (next_rd == HEAD_N) ||
                       (cnt_reg >= CW'(POOL - 1));

    always_comb begin
        state_next     = state_reg;
        req_next       = req_reg;
        node_next      = node_reg;
        at_next        = at_reg;
        nx_next        = nx_reg;
        val_next       = val_reg;
        st_next        = st_reg;
        free_next      = free_reg;
        head_next_next = head_next_reg;
        tail_prev_next = tail_prev_reg;
        cnt_next       = cnt_reg;

        n_we = 1'b0; n_waddr = '0; n_wdata = '0; n_re = 1'b0; n_raddr = '0;
        p_we = 1'b0; p_waddr = '0; p_wdata = '0; p_re = 1'b0; p_raddr = '0;
        v_we = 1'b0; v_waddr = '0; v_wdata = '0; v_re = 1'b0; v_raddr = '0;

        out_load            = 1'b0;
        out_item.elem_value = '0;
        out_item.last       = 1'b1;
        out_item.status     = st_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    val_next = s_tdata[PW +: VW];
                    req_next = s_tuser;
                    case (s_tuser)
                        idll_pkg::REQ_PUSH_FRONT, idll_pkg::REQ_PUSH_BACK: begin
                            if (pool_full) begin
                                st_next    = idll_pkg::STAT_FULL;
                                state_next = S_RESP;
                            end else begin
                                at_next = (s_tuser == idll_pkg::REQ_PUSH_FRONT) ?
                                          HEAD_N : tail_prev_reg;
                                n_re       = 1'b1;
                                n_raddr    = at_next;
                                state_next = S_INS_RD;
                            end
                        end
                        idll_pkg::REQ_DELETE, idll_pkg::REQ_INS_LEFT,
                        idll_pkg::REQ_INS_RIGHT: begin
                            if (!pos_ok) begin
                                st_next    = idll_pkg::STAT_BAD_POS;
                                state_next = S_RESP;
                            end else begin
                                // fetch links and live flag of the named node
                                node_next  = pos_idx;
                                at_next    = pos_idx;
                                n_re       = 1'b1;
                                n_raddr    = pos_idx;
                                p_re       = 1'b1;
                                p_raddr    = pos_idx;
                                v_re       = 1'b1;
                                v_raddr    = pos_idx;
                                state_next = S_CHECK;
                            end
                        end
                        idll_pkg::REQ_DUMP: begin
                            if (head_next_reg == TAIL_N) begin
                                st_next    = idll_pkg::STAT_EMPTY;
                                state_next = S_RESP;
                            end else begin
                                cnt_next   = '0;
                                n_re       = 1'b1;
                                n_raddr    = head_next_reg;
                                v_re       = 1'b1;
                                v_raddr    = head_next_reg;
                                state_next = S_DUMP;
                            end
                        end
                        default: begin
                            // unknown request: drop it silently
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CHECK: begin
                // position is checked ahead of the pool; read data holds meanwhile
                if (!v_rdata[VW]) begin
                    st_next    = idll_pkg::STAT_BAD_POS;
                    state_next = S_RESP;
                end else if (req_reg == idll_pkg::REQ_DELETE) begin
                    state_next = S_DEL_RD;
                end else if (pool_full) begin
                    st_next    = idll_pkg::STAT_FULL;
                    state_next = S_RESP;
                end else if (req_reg == idll_pkg::REQ_INS_LEFT) begin
                    state_next = S_LEFT_RD;
                end else begin
                    state_next = S_INS_RD;
                end
            end
            S_LEFT_RD: begin
                at_next    = prev_rd;
                n_re       = 1'b1;
                n_raddr    = prev_rd;
                state_next = S_INS_RD;
            end
            S_INS_RD: begin
                nx_next    = next_rd;
                n_we       = 1'b1;
                n_waddr    = new_node;
                n_wdata    = next_rd;
                p_we       = 1'b1;
                p_waddr    = new_node;
                p_wdata    = at_reg;
                v_we       = 1'b1;
                v_waddr    = new_node;
                v_wdata    = {1'b1, val_reg};
                state_next = S_INS_WR;
            end
            S_INS_WR: begin
                n_we    = 1'b1;
                n_waddr = at_reg;
                n_wdata = new_node;
                p_we    = 1'b1;
                p_waddr = nx_reg;
                p_wdata = new_node;
                if (at_reg == HEAD_N) begin
                    head_next_next = new_node;
                end
                if (nx_reg == TAIL_N) begin
                    tail_prev_next = new_node;
                end
                free_next  = free_reg + 1'b1;
                st_next    = idll_pkg::STAT_OK;
                state_next = S_RESP;
            end
            S_DEL_RD: begin
                // unlink: prev's next skips over the node, next's prev likewise
                n_we    = 1'b1;
                n_waddr = prev_rd;
                n_wdata = next_rd;
                p_we    = 1'b1;
                p_waddr = next_rd;
                p_wdata = prev_rd;
                if (prev_rd == HEAD_N) begin
                    head_next_next = next_rd;
                end
                if (next_rd == TAIL_N) begin
                    tail_prev_next = prev_rd;
                end
                // clear the live flag, keep the value
                v_we       = 1'b1;
                v_waddr    = node_reg;
                v_wdata    = {1'b0, v_rdata[VW-1:0]};
                st_next    = idll_pkg::STAT_OK;
                state_next = S_RESP;
            end
            S_DUMP: begin
                out_item.elem_value = v_rdata[VW-1:0];
                out_item.last       = dump_end;
                out_item.status     = idll_pkg::STAT_OK;
                if (out_ready) begin
                    out_load = 1'b1;
                    if (dump_end) begin
                        state_next = S_IDLE;
                    end else begin
                        // advance to the next node while this item leaves
                        cnt_next = cnt_reg + 1'b1;
                        n_re     = 1'b1;
                        n_raddr  = next_rd;
                        v_re     = 1'b1;
                        v_raddr  = next_rd;
                    end
                end
            end
            S_RESP: begin
                if (out_ready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            free_reg      <= FW'(idll_pkg::FIRST_FREE);
            head_next_reg <= TAIL_N;
            tail_prev_reg <= HEAD_N;
            cnt_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            free_reg      <= free_next;
            head_next_reg <= head_next_next;
            tail_prev_reg <= tail_prev_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg  <= req_next;
        node_reg <= node_next;
        at_reg   <= at_next;
        nx_reg   <= nx_next;
        val_reg  <= val_next;
        st_reg   <= st_next;
        if (n_re) begin
            nrd_addr_reg <= n_raddr;
        end
        if (p_re) begin
            prd_addr_reg <= p_raddr;
        end
    end

    `IDLL_ASSERT_IMP(a_free_bound, 1'b1, free_reg <= FW'(DEPTH), "allocation ran past the pool")
    `IDLL_ASSERT_IMP(a_head_link, 1'b1, head_next_reg != HEAD_N, "head sentinel links to itself")
    `IDLL_ASSERT_NXT(a_alloc_step, state_reg == S_INS_WR, free_reg == $past(free_reg) + 1'b1, "insert did not take exactly one node")
    `IDLL_ASSERT_IMP(a_dump_node, state_reg == S_DUMP, nrd_addr_reg != HEAD_N && nrd_addr_reg != TAIL_N, "dump walked onto a sentinel")

endmodule
